// File: hw/rtl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types, constants and tables for the line-follow PID steering block.
// ----------------------------------------------------------------------------
package lfps_pkg;

    // sensor array
    localparam int NUM_SENSORS  = 6;
    localparam int INPUT_COUNT  = 6;
    localparam int WEIGHT_SLOTS = 8;
    localparam int SIDX_W       = $clog2(WEIGHT_SLOTS);

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int CLAMP_W  = 8;
    localparam int GAIN_W   = 16;
    localparam int BASE_W   = 10;
    localparam int DUTY_W   = 16;
    localparam int MODE_W   = 2;
    localparam int POS_W    = 10;
    localparam int WGT_W    = 10;

    // centroid arithmetic
    localparam int DEN_W   = 11;               // up to 6 * 255
    localparam int NUM_W   = 20;               // up to +/- 255 * 600, signed
    localparam int Q_W     = 9;                // quotient magnitude <= 300
    localparam int REM_W   = DEN_W + Q_W - 1;  // |num| < 2**19
    localparam int POS_MAX = 300;

    // PID arithmetic
    localparam int ERR_W   = 11;
    localparam int DERR_W  = 12;
    localparam int INTEG_W = 32;
    localparam int MULB_W  = INTEG_W + 1;
    localparam int MULA_W  = GAIN_W + 1;
    localparam int ACC_W   = MULA_W + MULB_W;

    // sequencer step counter, covers sensor and divider steps
    localparam int CNT_W = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = 3'd5;

    // direction codes
    localparam logic [MODE_W-1:0] MODE_FWD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPIN_L = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPIN_R = 2'd2;

    // multiplier operand select
    typedef enum logic [1:0] {
        MSEL_P,
        MSEL_I,
        MSEL_D
    } t_msel;

    // configuration register set
    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [BASE_W-1:0]  base_duty;
        logic [CLAMP_W-1:0] clamp_high;
        logic [CLAMP_W-1:0] clamp_low;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             sense;
        logic [CNT_W-1:0] step;
        logic             div_init;
        logic             div_step;
        logic             integ;
        logic             mul_en;
        t_msel            mul_sel;
        logic             acc_load;
        logic             acc_add;
        logic             duty;
        logic             out_load;
    } t_cmd;

    // sensor position weights, unused slots weigh zero
    function automatic logic signed [WGT_W-1:0] lfps_weight(input logic [SIDX_W-1:0] idx);
        logic signed [WGT_W-1:0] w;
        case (idx)
            3'd0:    w = -10'sd300;
            3'd1:    w = -10'sd200;
            3'd2:    w = -10'sd100;
            3'd3:    w = 10'sd100;
            3'd4:    w = 10'sd200;
            3'd5:    w = 10'sd300;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/lfps_regs.sv
// ----------------------------------------------------------------------------
// lfps_regs
// Configuration register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module lfps_regs
    import lfps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p     <= 16'd640;
            r_cfg.gain_i     <= 16'd0;
            r_cfg.gain_d     <= 16'd640;
            r_cfg.base_duty  <= 10'd200;
            r_cfg.clamp_high <= 8'd12;
            r_cfg.clamp_low  <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GAIN_P:     r_cfg.gain_p     <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:     r_cfg.gain_i     <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:     r_cfg.gain_d     <= i_cfg_data[GAIN_W-1:0];
                REG_BASE_DUTY:  r_cfg.base_duty  <= i_cfg_data[BASE_W-1:0];
                REG_CLAMP_HIGH: r_cfg.clamp_high <= i_cfg_data[CLAMP_W-1:0];
                REG_CLAMP_LOW:  r_cfg.clamp_low  <= i_cfg_data[CLAMP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: hw/rtl/lfps_ctrl.sv
// ----------------------------------------------------------------------------
// lfps_ctrl
// Sequencer: walks one control period through sensor, divide, PID and duty
// steps, and owns the output valid flag.
// ----------------------------------------------------------------------------
module lfps_ctrl
    import lfps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SENSE,
        S_ABS,
        S_DIV,
        S_INTEG,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_DUTY,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.step     = r_cnt;
        o_cmd.mul_sel  = MSEL_P;
        case (r_state)
            S_IDLE:  o_cmd.load     = i_in_valid;
            S_SENSE: o_cmd.sense    = 1'b1;
            S_ABS:   o_cmd.div_init = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_INTEG: o_cmd.integ    = 1'b1;
            S_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_P;
            end
            S_MUL_I: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MSEL_I;
                o_cmd.acc_load = 1'b1;
            end
            S_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_D;
                o_cmd.acc_add = 1'b1;
            end
            S_ACC:   o_cmd.acc_add  = 1'b1;
            S_DUTY:  o_cmd.duty     = 1'b1;
            S_OUT:   o_cmd.out_load = out_free;
            default: ;
        endcase
    end

    // state, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= o_cmd.out_load || (r_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SENSE;
                        r_cnt   <= '0;
                    end
                end
                S_SENSE: begin
                    if (r_cnt == CNT_W'(NUM_SENSORS - 1)) begin
                        r_state <= S_ABS;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ABS: begin
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(Q_W - 1)) begin
                        r_state <= S_INTEG;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_INTEG: r_state <= S_MUL_P;
                S_MUL_P: r_state <= S_MUL_I;
                S_MUL_I: r_state <= S_MUL_D;
                S_MUL_D: r_state <= S_ACC;
                S_ACC:   r_state <= S_DUTY;
                S_DUTY:  r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over a pending result");

    // an accepted transaction starts the sensor pass at slot zero
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SENSE && r_cnt == '0))
        else $error("sensor pass did not start after accept");

    // loading a result presents it and frees the input side
    a_load_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_out_valid && !o_in_stall))
        else $error("loaded result not presented");

endmodule

// File: hw/rtl/lfps_dp.sv
// ----------------------------------------------------------------------------
// lfps_dp
// Datapath: sensor accumulation, restoring divider, PID state, shared
// multiplier with accumulator, duty rounding and the output registers.
// ----------------------------------------------------------------------------
module lfps_dp
    import lfps_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  t_cfg                       i_cfg,
    input  logic [SAMPLE_W-1:0]        i_sample0,
    input  logic [SAMPLE_W-1:0]        i_sample1,
    input  logic [SAMPLE_W-1:0]        i_sample2,
    input  logic [SAMPLE_W-1:0]        i_sample3,
    input  logic [SAMPLE_W-1:0]        i_sample4,
    input  logic [SAMPLE_W-1:0]        i_sample5,
    output logic signed [DUTY_W-1:0]   o_left_duty,
    output logic signed [DUTY_W-1:0]   o_right_duty,
    output logic [MODE_W-1:0]          o_drive_mode,
    output logic signed [POS_W-1:0]    o_line_position
);

    localparam logic signed [ACC_W-1:0] DUTY_RND = ACC_W'(255);
    localparam logic signed [ACC_W-1:0] DUTY_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] DUTY_MIN = -ACC_W'(32768);

    // latched samples and centroid accumulators
    logic [SAMPLE_W-1:0]       r_samp [INPUT_COUNT];
    logic signed [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]          r_den;

    // divider
    logic [REM_W-1:0]          r_rem;
    logic [REM_W-1:0]          r_dsh;
    logic [Q_W-1:0]            r_quot;
    logic                      r_neg;

    // PID state and operands
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_last_err;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DERR_W-1:0]  r_derr;
    logic signed [POS_W-1:0]   r_pos;

    // multiplier and accumulator
    logic signed [ACC_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_lq;
    logic signed [ACC_W-1:0]   r_rq;

    // output registers
    logic signed [DUTY_W-1:0]  r_left;
    logic signed [DUTY_W-1:0]  r_right;
    logic [MODE_W-1:0]         r_mode;
    logic signed [POS_W-1:0]   r_pos_out;

    logic [SIDX_W-1:0]           sidx;
    logic [SAMPLE_W-1:0]         samp;
    logic [CLAMP_W-1:0]          clamped;
    logic [CLAMP_W-1:0]          inv;
    logic signed [WGT_W+CLAMP_W:0] term;
    logic signed [NUM_W-1:0]     num_neg;
    logic [REM_W-1:0]            num_mag;
    logic                        div_ge;
    logic signed [POS_W-1:0]     n_pos;
    logic signed [POS_W-1:0]     quot_s;
    logic signed [ERR_W-1:0]     n_err;
    logic signed [INTEG_W:0]     integ_sum;
    logic signed [INTEG_W-1:0]   n_integ;
    logic [GAIN_W-1:0]           mul_a;
    logic signed [MULB_W-1:0]    mul_b;
    logic signed [ACC_W-1:0]     mul_p;
    logic signed [ACC_W-1:0]     base_sh;
    logic signed [ACC_W-1:0]     v_left;
    logic signed [ACC_W-1:0]     v_right;
    logic signed [DUTY_W-1:0]    sat_left;
    logic signed [DUTY_W-1:0]    sat_right;

    // divide by 256 toward zero
    function automatic logic signed [ACC_W-1:0] div256(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v[ACC_W-1] ? (v + DUTY_RND) : v;
        return t >>> 8;
    endfunction

    // saturate to the duty range
    function automatic logic signed [DUTY_W-1:0] sat_duty(input logic signed [ACC_W-1:0] v);
        logic signed [DUTY_W-1:0] r;
        if (v > DUTY_MAX) begin
            r = DUTY_MAX[DUTY_W-1:0];
        end else if (v < DUTY_MIN) begin
            r = DUTY_MIN[DUTY_W-1:0];
        end else begin
            r = v[DUTY_W-1:0];
        end
        return r;
    endfunction

    // clamp, invert and weight the current sensor slot
    always_comb begin
        sidx = i_cmd.step[SIDX_W-1:0];
        if (sidx < SIDX_W'(INPUT_COUNT)) begin
            samp = r_samp[sidx];
        end else begin
            samp = '0;
        end
        if (samp > SAMPLE_W'(i_cfg.clamp_high)) begin
            clamped = i_cfg.clamp_high;
        end else if (samp < SAMPLE_W'(i_cfg.clamp_low)) begin
            clamped = i_cfg.clamp_low;
        end else begin
            clamped = samp[CLAMP_W-1:0];
        end
        inv  = i_cfg.clamp_high - clamped;
        term = $signed({1'b0, inv}) * lfps_weight(sidx);
    end

    // divider magnitude and trial subtract
    assign num_neg = -r_num;
    assign num_mag = r_num[NUM_W-1] ? num_neg[REM_W-1:0] : r_num[REM_W-1:0];
    assign div_ge  = (r_rem >= r_dsh);

    // centroid sign, error and saturating integral
    always_comb begin
        quot_s = $signed({1'b0, r_quot});
        if (r_den == '0) begin
            n_pos = '0;
        end else if (r_neg) begin
            n_pos = -quot_s;
        end else begin
            n_pos = quot_s;
        end
        n_err     = -ERR_W'(n_pos);
        integ_sum = (INTEG_W + 1)'(r_integ) + (INTEG_W + 1)'(n_err);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            n_integ = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                         : {1'b0, {(INTEG_W - 1){1'b1}}};
        end else begin
            n_integ = integ_sum[INTEG_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MSEL_P: begin
                mul_a = i_cfg.gain_p;
                mul_b = MULB_W'(r_err);
            end
            MSEL_I: begin
                mul_a = i_cfg.gain_i;
                mul_b = MULB_W'(r_integ);
            end
            MSEL_D: begin
                mul_a = i_cfg.gain_d;
                mul_b = MULB_W'(r_derr);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = $signed({1'b0, mul_a}) * mul_b;
    end

    // duty sums and saturation
    assign base_sh   = ACC_W'($signed({1'b0, i_cfg.base_duty, 8'b0}));
    assign v_left    = base_sh - r_acc;
    assign v_right   = base_sh + r_acc;
    assign sat_left  = sat_duty(r_lq);
    assign sat_right = sat_duty(r_rq);

    // PID state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else if (i_cmd.integ) begin
            r_integ    <= n_integ;
            r_last_err <= n_err;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_samp[0] <= i_sample0;
            r_samp[1] <= i_sample1;
            r_samp[2] <= i_sample2;
            r_samp[3] <= i_sample3;
            r_samp[4] <= i_sample4;
            r_samp[5] <= i_sample5;
            r_num     <= '0;
            r_den     <= '0;
        end
        if (i_cmd.sense) begin
            r_num <= r_num + NUM_W'(term);
            r_den <= r_den + DEN_W'(inv);
        end
        if (i_cmd.div_init) begin
            r_rem  <= num_mag;
            r_dsh  <= {r_den, {(Q_W - 1){1'b0}}};
            r_quot <= '0;
            r_neg  <= r_num[NUM_W-1];
        end
        if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[Q_W-2:0], div_ge};
        end
        if (i_cmd.integ) begin
            r_err  <= n_err;
            r_derr <= DERR_W'(n_err) - DERR_W'(r_last_err);
            r_pos  <= n_pos;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.acc_load) begin
            r_acc <= r_prod;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.duty) begin
            r_lq <= div256(v_left);
            r_rq <= div256(v_right);
        end
        if (i_cmd.out_load) begin
            r_left    <= sat_left;
            r_right   <= sat_right;
            r_pos_out <= r_pos;
            if (sat_left < 0) begin
                r_mode <= MODE_SPIN_L;
            end else if (sat_right < 0) begin
                r_mode <= MODE_SPIN_R;
            end else begin
                r_mode <= MODE_FWD;
            end
        end
    end

    assign o_left_duty     = r_left;
    assign o_right_duty    = r_right;
    assign o_drive_mode    = r_mode;
    assign o_line_position = r_pos_out;

    // centroid magnitude never exceeds the outer weight
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.integ && r_den != '0) |-> (r_quot <= Q_W'(POS_MAX)))
        else $error("centroid quotient out of range");

endmodule

// File: hw/rtl/line_follow_pid_steering.sv
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// Line-sensor centroid and PID steering: six samples in, two motor duties,
// a direction code and the line position out.
//
//   channel  handshake                  payload
//   -------  -------------------------  ---------------------------------------
//   input    i_in_valid / o_in_stall    i_sample0 .. i_sample5
//   output   o_out_valid / i_out_stall  o_left_duty, o_right_duty,
//                                       o_drive_mode, o_line_position
//   config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// From accept to the next accept, one transaction steps through each sensor
// in the accumulator, the bit-serial restoring divider, three passes of the
// shared multiplier, and the duty rounding and saturation steps.
// Synchronous active-low reset clears the sequencer, the output valid flag,
// the integral and the previous error, and loads the register defaults.
// A stalled result stays in the output register; the next transaction is
// computed meanwhile and waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module line_follow_pid_steering
    import lfps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [SAMPLE_W-1:0]      i_sample0,
    input  logic [SAMPLE_W-1:0]      i_sample1,
    input  logic [SAMPLE_W-1:0]      i_sample2,
    input  logic [SAMPLE_W-1:0]      i_sample3,
    input  logic [SAMPLE_W-1:0]      i_sample4,
    input  logic [SAMPLE_W-1:0]      i_sample5,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DUTY_W-1:0] o_left_duty,
    output logic signed [DUTY_W-1:0] o_right_duty,
    output logic [MODE_W-1:0]        o_drive_mode,
    output logic signed [POS_W-1:0]  o_line_position,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_cfg cfg;
    t_cmd cmd;

    // configuration registers
    lfps_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer
    lfps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // datapath
    lfps_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (cfg),
        .i_sample0       (i_sample0),
        .i_sample1       (i_sample1),
        .i_sample2       (i_sample2),
        .i_sample3       (i_sample3),
        .i_sample4       (i_sample4),
        .i_sample5       (i_sample5),
        .o_left_duty     (o_left_duty),
        .o_right_duty    (o_right_duty),
        .o_drive_mode    (o_drive_mode),
        .o_line_position (o_line_position)
    );

endmodule

// File: verif/line_follow_pid_steering_test.sv
// ----------------------------------------------------------------------------
// line_follow_pid_steering_test
// Self-checking bench for the line-follow PID steering block. A queue-fed
// driver sends sensor periods, a monitor checks each steering result
// against an in-bench model of the centroid and PID math. The model tracks
// register writes and the integral and previous-error state. Both sides
// idle and stall at random while the bench sweeps several register
// settings.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_test;
    import lfps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_SHOWN      = 10;
    localparam int  QUIET_LIMIT    = 4000;
    localparam int  LONG_HOLD      = 400;
    localparam int  SETTLE_CYCLES  = 60;
    localparam longint INTEG_MAX   = 64'sd2147483647;
    localparam longint INTEG_MIN   = -64'sd2147483648;
    localparam longint DUTY_MAX    = 64'sd32767;
    localparam longint DUTY_MIN    = -64'sd32768;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam t_cfg CFG_RESET = '{gain_p: 16'd640, gain_i: 16'd0, gain_d: 16'd640,
                                   base_duty: 10'd200, clamp_high: 8'd12,
                                   clamp_low: 8'd0};

    typedef logic [INPUT_COUNT-1:0][SAMPLE_W-1:0] t_samples;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
    } t_steer;

    // DUT connections
    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [SAMPLE_W-1:0]   i_sample0 = '0;
    logic [SAMPLE_W-1:0]   i_sample1 = '0;
    logic [SAMPLE_W-1:0]   i_sample2 = '0;
    logic [SAMPLE_W-1:0]   i_sample3 = '0;
    logic [SAMPLE_W-1:0]   i_sample4 = '0;
    logic [SAMPLE_W-1:0]   i_sample5 = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DUTY_W-1:0]     o_left_duty;
    logic [DUTY_W-1:0]     o_right_duty;
    logic [MODE_W-1:0]     o_drive_mode;
    logic [POS_W-1:0]      o_line_position;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // bench state
    t_samples pend_q[$];
    t_steer   steer_q[$];
    t_samples cur_smp;
    t_cfg     cfg_mirror = CFG_RESET;
    t_cfg     cur_cfg = CFG_RESET;
    logic signed [INTEG_W-1:0] integ_acc;
    logic signed [ERR_W-1:0]   prev_err;
    int  n_queued, n_accepted, n_results, n_errors;
    int  n_zero_sum, n_saturated, n_settings;
    int  holds_asked, holds_done;
    int  gap_left, stall_left, quiet_cycles;
    bit  no_idle;

    line_follow_pid_steering uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample0      (i_sample0),
        .i_sample1      (i_sample1),
        .i_sample2      (i_sample2),
        .i_sample3      (i_sample3),
        .i_sample4      (i_sample4),
        .i_sample5      (i_sample5),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_duty    (o_left_duty),
        .o_right_duty   (o_right_duty),
        .o_drive_mode   (o_drive_mode),
        .o_line_position(o_line_position),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // centroid, PID update and duty math for one control period
    function automatic t_steer predict_steering(input t_samples smp);
        t_steer res;
        logic [SAMPLE_W-1:0] raw;
        logic [CLAMP_W-1:0]  lvl, inv;
        int     den, num, centroid, err, wt;
        longint integ, pid_sum, left, right;
        den = 0;
        num = 0;
        for (int k = 0; k < NUM_SENSORS && k < WEIGHT_SLOTS; k++) begin
            raw = (k < INPUT_COUNT) ? smp[k] : '0;
            if (raw > cfg_mirror.clamp_high)
                lvl = cfg_mirror.clamp_high;
            else if (raw < cfg_mirror.clamp_low)
                lvl = cfg_mirror.clamp_low;
            else
                lvl = raw[CLAMP_W-1:0];
            inv = cfg_mirror.clamp_high - lvl;  // wraps mod 256 on crossed clamps
            // -300,-200,-100 on the left half, 100,200,300 on the right
            if (k >= INPUT_COUNT) wt = 0;
            else if (k < 3)       wt = (k - 3) * 100;
            else                  wt = (k - 2) * 100;
            den += int'(inv);
            num += int'(inv) * wt;
        end
        centroid = (den == 0) ? 0 : num / den;
        if (den == 0) n_zero_sum++;
        err = -centroid;

        integ = clip(longint'(integ_acc) + err, INTEG_MIN, INTEG_MAX);
        pid_sum = longint'(cfg_mirror.gain_p) * err
                + longint'(cfg_mirror.gain_i) * integ
                + longint'(cfg_mirror.gain_d) * (err - int'(prev_err));
        integ_acc = integ[INTEG_W-1:0];
        prev_err  = err[ERR_W-1:0];

        left  = (longint'(cfg_mirror.base_duty) * 256 - pid_sum) / 256;
        right = (longint'(cfg_mirror.base_duty) * 256 + pid_sum) / 256;
        if (left != clip(left, DUTY_MIN, DUTY_MAX) || right != clip(right, DUTY_MIN, DUTY_MAX))
            n_saturated++;
        left  = clip(left, DUTY_MIN, DUTY_MAX);
        right = clip(right, DUTY_MIN, DUTY_MAX);

        res.left_duty  = left[DUTY_W-1:0];
        res.right_duty = right[DUTY_W-1:0];
        if (left < 0)       res.mode = MODE_SPIN_L;
        else if (right < 0) res.mode = MODE_SPIN_R;
        else                res.mode = MODE_FWD;
        res.position = centroid[POS_W-1:0];
        return res;
    endfunction

    // register mirror, follows every accepted config write
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_mirror <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_GAIN_P:     cfg_mirror.gain_p     <= i_cfg_data;
                REG_GAIN_I:     cfg_mirror.gain_i     <= i_cfg_data;
                REG_GAIN_D:     cfg_mirror.gain_d     <= i_cfg_data;
                REG_BASE_DUTY:  cfg_mirror.base_duty  <= i_cfg_data[BASE_W-1:0];
                REG_CLAMP_HIGH: cfg_mirror.clamp_high <= i_cfg_data[CLAMP_W-1:0];
                REG_CLAMP_LOW:  cfg_mirror.clamp_low  <= i_cfg_data[CLAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // sensor driver: predicts on accept, then offers the next period
    always @(posedge i_clk) begin : p_drive
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
            integ_acc = '0;
            prev_err = '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                steer_q.push_back(predict_steering(cur_smp));
                n_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    cur_smp = pend_q.pop_front();
                    i_sample0 <= cur_smp[0];
                    i_sample1 <= cur_smp[1];
                    i_sample2 <= cur_smp[2];
                    i_sample3 <= cur_smp[3];
                    i_sample4 <= cur_smp[4];
                    i_sample5 <= cur_smp[5];
                    i_in_valid <= 1'b1;
                    gap_left = no_idle ? 0 : pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output back-pressure
    always @(posedge i_clk) begin : p_check
        t_steer want;
        bit hold;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (steer_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("Unexpected result %0d: left %0d right %0d mode %0d pos %0d",
                                 n_results, $signed(o_left_duty), $signed(o_right_duty),
                                 o_drive_mode, $signed(o_line_position));
                end else begin
                    want = steer_q.pop_front();
                    if (o_left_duty !== want.left_duty || o_right_duty !== want.right_duty ||
                        o_drive_mode !== want.mode || o_line_position !== want.position) begin
                        n_errors++;
                        if (n_errors <= MAX_SHOWN)
                            $display({"Mismatch at result %0d (exp/got): left %0d/%0d ",
                                      "right %0d/%0d mode %0d/%0d pos %0d/%0d"},
                                     n_results, $signed(want.left_duty), $signed(o_left_duty),
                                     $signed(want.right_duty), $signed(o_right_duty),
                                     want.mode, o_drive_mode,
                                     $signed(want.position), $signed(o_line_position));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                hold = 1'b1;
            end else if (holds_done < holds_asked) begin
                // long hold-off so the block backs up into its input
                holds_done++;
                stall_left = LONG_HOLD - 1;
                hold = 1'b1;
            end else if (no_idle || $urandom_range(0, 99) < 65) begin
                hold = 1'b0;
            end else begin
                stall_left = pick_gap();
                hold = 1'b1;
            end
            i_out_stall <= hold;
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: %0d cycles without a transaction, %0d results pending",
                     quiet_cycles, steer_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_item(input t_samples s);
        pend_q.push_back(s);
        n_queued++;
    endtask

    task automatic queue_six(input int a, input int b, input int c,
                             input int d, input int e, input int f);
        t_samples s;
        s[0] = SAMPLE_W'(a); s[1] = SAMPLE_W'(b); s[2] = SAMPLE_W'(c);
        s[3] = SAMPLE_W'(d); s[4] = SAMPLE_W'(e); s[5] = SAMPLE_W'(f);
        queue_item(s);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample(input int hi, input int lo);
        int r, top;
        r = $urandom_range(0, 99);
        top = ((hi > lo) ? hi : lo) + 2;
        if (r < 30) return SAMPLE_W'($urandom_range(0, 1023));
        if (r < 65) return SAMPLE_W'($urandom_range(0, top));
        if (r < 80) return SAMPLE_W'($urandom_range((lo < 2) ? 0 : lo - 2, lo + 2));
        if (r < 90) return SAMPLE_W'($urandom_range((hi < 2) ? 0 : hi - 2, hi + 2));
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    // mostly line-shaped periods (dark under one or two sensors), rest noise
    task automatic queue_random(input int n);
        t_samples s;
        int ctr;
        int hi, lo;
        hi = int'(cur_cfg.clamp_high);
        lo = int'(cur_cfg.clamp_low);
        repeat (n) begin
            if ($urandom_range(0, 99) < 55) begin
                ctr = $urandom_range(0, INPUT_COUNT - 1);
                for (int k = 0; k < INPUT_COUNT; k++) begin
                    if (k == ctr || (k == ctr + 1 && $urandom_range(0, 1)))
                        s[k] = SAMPLE_W'($urandom_range(0, hi));
                    else
                        s[k] = SAMPLE_W'($urandom_range(hi, 1023));
                end
            end else begin
                for (int k = 0; k < INPUT_COUNT; k++)
                    s[k] = rand_sample(hi, lo);
            end
            queue_item(s);
        end
    endtask

    // wait until every queued period has been accepted and checked
    task automatic wait_drain();
        while (n_accepted != n_queued || steer_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // full register load, bracketed by writes to unused indexes
    task automatic set_config(input t_cfg c);
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_GAIN_P, c.gain_p);
        write_reg(REG_GAIN_I, c.gain_i);
        write_reg(REG_GAIN_D, c.gain_d);
        write_reg(REG_BASE_DUTY, {6'($urandom), c.base_duty});
        write_reg(REG_CLAMP_HIGH, {8'($urandom), c.clamp_high});
        write_reg(REG_CLAMP_LOW, {8'($urandom), c.clamp_low});
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
        n_settings++;
    endtask

    function automatic logic [GAIN_W-1:0] rand_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return '0;
        if (r < 35) return '1;
        if (r < 70) return GAIN_W'($urandom_range(0, 2048));
        return GAIN_W'($urandom);
    endfunction

    function automatic t_cfg rand_settings();
        t_cfg c;
        int r;
        c.gain_p = rand_gain();
        c.gain_i = rand_gain();
        c.gain_d = rand_gain();
        r = $urandom_range(0, 99);
        c.base_duty = (r < 15) ? '0 : (r < 30) ? '1 : BASE_W'($urandom);
        r = $urandom_range(0, 99);
        c.clamp_high = (r < 10) ? '1 : (r < 15) ? '0 : CLAMP_W'($urandom);
        // crossed clamps about a quarter of the time
        if ($urandom_range(0, 3) == 0)
            c.clamp_low = CLAMP_W'($urandom_range(c.clamp_high, 255));
        else
            c.clamp_low = CLAMP_W'($urandom_range(0, c.clamp_high));
        return c;
    endfunction

    // half the items, a full drain, then the rest
    task automatic run_phase(input int n);
        queue_random(n / 2);
        wait_drain();
        queue_random(n - n / 2);
        wait_drain();
    endtask

    // stimulus sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed periods at reset settings (clamp 0..12)
        queue_six(0, 0, 0, 0, 0, 0);
        queue_six(1023, 1023, 1023, 1023, 1023, 1023);   // zero sum
        queue_six(0, 1023, 1023, 1023, 1023, 1023);      // far left
        queue_six(1023, 0, 1023, 1023, 1023, 1023);
        queue_six(1023, 1023, 0, 1023, 1023, 1023);
        queue_six(1023, 1023, 1023, 0, 1023, 1023);
        queue_six(1023, 1023, 1023, 1023, 0, 1023);
        queue_six(1023, 1023, 1023, 1023, 1023, 0);      // far right
        queue_six(0, 1023, 1023, 1023, 1023, 0);
        queue_six(0, 6, 1023, 1023, 1023, 1023);         // truncation, negative
        queue_six(1023, 1023, 1023, 1023, 6, 0);         // truncation, positive
        queue_six(12, 12, 12, 12, 12, 12);
        queue_six(11, 11, 11, 11, 11, 11);
        queue_six(13, 13, 13, 13, 13, 13);
        queue_six(0, 1023, 0, 1023, 0, 1023);
        queue_six(1023, 0, 1023, 0, 1023, 0);
        queue_six('h2AA, 'h155, 'h2AA, 'h155, 'h2AA, 'h155);
        queue_six(0, 2, 4, 6, 8, 10);
        queue_six(10, 8, 6, 4, 2, 0);
        queue_six(0, 1023, 1023, 1023, 1023, 1023);      // swing left to right
        queue_six(1023, 1023, 1023, 1023, 1023, 0);
        queue_six(0, 1023, 1023, 1023, 1023, 1023);
        queue_six(1, 2, 3, 9, 10, 11);
        queue_six(512, 256, 128, 64, 32, 16);
        queue_six(3, 5, 7, 1023, 1023, 1023);
        wait_drain();

        // long receiver hold-off while periods keep coming
        holds_asked++;
        queue_random(40);
        wait_drain();

        // extreme settings: full gains, top base duty, widest clamp
        set_config('{gain_p: '1, gain_i: '1, gain_d: '1, base_duty: '1,
                     clamp_high: '1, clamp_low: '0});
        run_phase(170);

        // everything zero
        set_config('{gain_p: '0, gain_i: '0, gain_d: '0, base_duty: '0,
                     clamp_high: '0, clamp_low: '0});
        run_phase(60);

        // crossed clamps, inversion wraps
        set_config('{gain_p: 16'd900, gain_i: 16'd40, gain_d: 16'd300, base_duty: 10'd512,
                     clamp_high: 8'd30, clamp_low: 8'd200});
        run_phase(170);

        // back to back, no idling on either side
        no_idle = 1'b1;
        set_config('{gain_p: 16'd256, gain_i: 16'd256, gain_d: 16'd0, base_duty: 10'd0,
                     clamp_high: 8'd200, clamp_low: 8'd100});
        run_phase(170);
        no_idle = 1'b0;

        repeat (4) begin
            set_config(rand_settings());
            holds_asked++;
            run_phase(205);
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        n_errors += steer_q.size();

        $display("Checked %0d steering results over %0d register settings, %0d long hold-offs",
                 n_results, n_settings + 1, holds_done);
        $display("Zero-sum periods %0d, periods with saturated duty %0d, failures %0d",
                 n_zero_sum, n_saturated, n_errors);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
